[src/aabb_pkg.sv]
// Shared types, register indexes and helpers for the box point query block.
// No dependencies; compiled before the interfaces and modules.
package aabb_pkg;

	localparam int NUM_AXES  = 3;
	localparam int NUM_FACES = 2 * NUM_AXES;
	localparam int ADDR_W    = 5;

	typedef logic signed [31:0] coord_t;
	typedef logic signed [32:0] dist_t;
	typedef logic signed [33:0] span_t;
	typedef logic [2:0]         face_idx_t;
	typedef logic [2:0]         reg_idx_t;
	typedef logic [2:0]         rank_t;

	localparam face_idx_t LAST_FACE = face_idx_t'(NUM_FACES - 1);

	localparam reg_idx_t REG_MIN_X = 3'd0;
	localparam reg_idx_t REG_MIN_Y = 3'd1;
	localparam reg_idx_t REG_MIN_Z = 3'd2;
	localparam reg_idx_t REG_MAX_X = 3'd3;
	localparam reg_idx_t REG_MAX_Y = 3'd4;
	localparam reg_idx_t REG_MAX_Z = 3'd5;

	typedef struct packed {
		logic [NUM_FACES-1:0] best_oh;
		logic [NUM_FACES-1:0] second_oh;
		face_idx_t            best_idx;
	} face_sel_t;

	function automatic coord_t sat32(input span_t v);
		coord_t r;
		if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
			r = v[31:0];
		end else if (v[33]) begin
			r = {1'b1, 31'h0};
		end else begin
			r = {1'b0, {31{1'b1}}};
		end
		return r;
	endfunction

endpackage

[src/aabb_if.sv]
// Valid/ready channel interfaces for query points and query results.
// Depends on aabb_pkg for the coordinate and face index types.
interface aabb_query_if;
	logic                valid;
	logic                ready;
	aabb_pkg::coord_t    point_x;
	aabb_pkg::coord_t    point_y;
	aabb_pkg::coord_t    point_z;

	modport source(output valid, output point_x, output point_y, output point_z, input ready);
	modport sink(input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface aabb_result_if;
	logic                  valid;
	logic                  ready;
	logic                  inside_res;
	aabb_pkg::coord_t      clamp_x;
	aabb_pkg::coord_t      clamp_y;
	aabb_pkg::coord_t      clamp_z;
	aabb_pkg::face_idx_t   face_index;
	aabb_pkg::coord_t      face_x;
	aabb_pkg::coord_t      face_y;
	aabb_pkg::coord_t      face_z;
	aabb_pkg::coord_t      edge_x;
	aabb_pkg::coord_t      edge_y;
	aabb_pkg::coord_t      edge_z;

	modport source(output valid, output inside_res, output clamp_x, output clamp_y,
		output clamp_z, output face_index, output face_x, output face_y, output face_z,
		output edge_x, output edge_y, output edge_z, input ready);
	modport sink(input valid, input inside_res, input clamp_x, input clamp_y,
		input clamp_z, input face_index, input face_x, input face_y, input face_z,
		input edge_x, input edge_y, input edge_z, output ready);
endinterface

[src/aabb_select.sv]
// Ranks the six face distances and picks the nearest and second nearest face.
// Ties go to the lower face index. Depends on aabb_pkg.
module aabb_select (
	input  aabb_pkg::dist_t   dist_in [aabb_pkg::NUM_FACES],
	output aabb_pkg::face_sel_t sel
);
	import aabb_pkg::*;

	rank_t rank [NUM_FACES];

	// rank of a face = number of faces ordered ahead of it by (distance, index)
	always_comb begin
		for (int k = 0; k < NUM_FACES; k++) begin
			rank[k] = '0;
			for (int j = 0; j < NUM_FACES; j++) begin
				if (j < k) begin
					rank[k] = rank[k] + rank_t'(dist_in[j] <= dist_in[k]);
				end else if (j > k) begin
					rank[k] = rank[k] + rank_t'(dist_in[j] < dist_in[k]);
				end
			end
		end
	end

	always_comb begin
		sel = '0;
		for (int k = 0; k < NUM_FACES; k++) begin
			sel.best_oh[k]   = (rank[k] == rank_t'(0));
			sel.second_oh[k] = (rank[k] == rank_t'(1));
			if (rank[k] == rank_t'(0)) begin
				sel.best_idx = sel.best_idx | face_idx_t'(k);
			end
		end
	end

endmodule

[src/aabb_point_queries.sv]
// Top level: box bound registers on an APB-style port and the query pipeline.
// Depends on aabb_pkg, aabb_if.sv and aabb_select.
//
// Pipeline: a point passes through the input register, the distance register
// and the result register before its result is valid.
// Throughput: one point per cycle; stalls on the result side back up through
// the three registers. Reset clears the stage valid bits and box bounds to 0.
module aabb_point_queries (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [aabb_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	aabb_query_if.sink                  query,
	aabb_result_if.source               result
);
	import aabb_pkg::*;

	// box bound registers
	coord_t   box_min_q [NUM_AXES];
	coord_t   box_max_q [NUM_AXES];
	reg_idx_t reg_idx;
	logic     cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				box_min_q[a] <= '0;
				box_max_q[a] <= '0;
			end
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_MIN_X: box_min_q[0] <= pwdata;
				REG_MIN_Y: box_min_q[1] <= pwdata;
				REG_MIN_Z: box_min_q[2] <= pwdata;
				REG_MAX_X: box_max_q[0] <= pwdata;
				REG_MAX_Y: box_max_q[1] <= pwdata;
				REG_MAX_Z: box_max_q[2] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MIN_X: prdata = box_min_q[0];
			REG_MIN_Y: prdata = box_min_q[1];
			REG_MIN_Z: prdata = box_min_q[2];
			REG_MAX_X: prdata = box_max_q[0];
			REG_MAX_Y: prdata = box_max_q[1];
			REG_MAX_Z: prdata = box_max_q[2];
			default:   prdata = '0;
		endcase
	end

	// pipeline control
	logic valid_s1, valid_s2, valid_s3;
	logic en_s1, en_s2, en_s3;

	assign en_s3       = !valid_s3 || result.ready;
	assign en_s2       = !valid_s2 || en_s3;
	assign en_s1       = !valid_s1 || en_s2;
	assign query.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= query.valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
		end
	end

	// stage 1: input register
	coord_t point_s1 [NUM_AXES];

	always_ff @(posedge clk) begin
		if (query.valid && en_s1) begin
			point_s1[0] <= query.point_x;
			point_s1[1] <= query.point_y;
			point_s1[2] <= query.point_z;
		end
	end

	// stage 1 -> 2: distances, clamp, inside test, same-axis edge sum
	dist_t  dist_c   [NUM_FACES];
	coord_t clamp_c  [NUM_AXES];
	span_t  span_c   [NUM_AXES];
	logic   inside_c;

	always_comb begin
		inside_c = 1'b1;
		for (int a = 0; a < NUM_AXES; a++) begin
			dist_c[2*a]   = dist_t'(box_max_q[a]) - dist_t'(point_s1[a]);
			dist_c[2*a+1] = dist_t'(point_s1[a]) - dist_t'(box_min_q[a]);
			if (!(point_s1[a] > box_min_q[a] && point_s1[a] < box_max_q[a])) begin
				inside_c = 1'b0;
			end
			// max bound is tested first, so an inverted box clamps to min below max, else to max
			if (point_s1[a] < box_max_q[a]) begin
				clamp_c[a] = (point_s1[a] > box_min_q[a]) ? point_s1[a] : box_min_q[a];
			end else begin
				clamp_c[a] = box_max_q[a];
			end
			// both moves on one axis land at max + min - p in either order
			span_c[a] = span_t'(box_max_q[a]) + span_t'(box_min_q[a]) - span_t'(point_s1[a]);
		end
	end

	coord_t point_s2 [NUM_AXES];
	dist_t  dist_s2  [NUM_FACES];
	coord_t clamp_s2 [NUM_AXES];
	span_t  span_s2  [NUM_AXES];
	logic   inside_s2;

	always_ff @(posedge clk) begin
		if (valid_s1 && en_s2) begin
			point_s2  <= point_s1;
			dist_s2   <= dist_c;
			clamp_s2  <= clamp_c;
			span_s2   <= span_c;
			inside_s2 <= inside_c;
		end
	end

	// stage 2 -> 3: face selection and moves
	face_sel_t sel;

	aabb_select u_select (
		.dist_in (dist_s2),
		.sel     (sel)
	);

	coord_t face_c [NUM_AXES];
	coord_t edge_c [NUM_AXES];

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			face_c[a] = point_s2[a];
			if (sel.best_oh[2*a]) begin
				face_c[a] = box_max_q[a];
			end else if (sel.best_oh[2*a+1]) begin
				face_c[a] = box_min_q[a];
			end

			if ((sel.best_oh[2*a] || sel.best_oh[2*a+1]) &&
			    (sel.second_oh[2*a] || sel.second_oh[2*a+1])) begin
				edge_c[a] = sat32(span_s2[a]);
			end else if (sel.best_oh[2*a] || sel.second_oh[2*a]) begin
				edge_c[a] = box_max_q[a];
			end else if (sel.best_oh[2*a+1] || sel.second_oh[2*a+1]) begin
				edge_c[a] = box_min_q[a];
			end else begin
				edge_c[a] = point_s2[a];
			end
		end
	end

	// stage 3: result register
	logic      inside_s3;
	coord_t    clamp_s3 [NUM_AXES];
	face_idx_t face_idx_s3;
	coord_t    face_s3  [NUM_AXES];
	coord_t    edge_s3  [NUM_AXES];

	always_ff @(posedge clk) begin
		if (valid_s2 && en_s3) begin
			inside_s3   <= inside_s2;
			clamp_s3    <= clamp_s2;
			face_idx_s3 <= sel.best_idx;
			face_s3     <= face_c;
			edge_s3     <= edge_c;
		end
	end

	assign result.valid      = valid_s3;
	assign result.inside_res = inside_s3;
	assign result.clamp_x    = clamp_s3[0];
	assign result.clamp_y    = clamp_s3[1];
	assign result.clamp_z    = clamp_s3[2];
	assign result.face_index = face_idx_s3;
	assign result.face_x     = face_s3[0];
	assign result.face_y     = face_s3[1];
	assign result.face_z     = face_s3[2];
	assign result.edge_x     = edge_s3[0];
	assign result.edge_y     = edge_s3[1];
	assign result.edge_z     = edge_s3[2];

	// checks
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(query.valid && query.ready) |=> valid_s1)
		else $error("accepted point did not reach the input register");

	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ($onehot(sel.best_oh) && $onehot(sel.second_oh)))
		else $error("nearest or second nearest face not unique");

	a_sel_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((sel.best_oh & sel.second_oh) == '0))
		else $error("nearest and second nearest face coincide");

	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.face_index <= LAST_FACE))
		else $error("face index out of range");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !result.ready && valid_s2 && valid_s1) |-> !query.ready)
		else $error("point accepted while the pipeline is full and stalled");

endmodule
